// File: rtl/core/uart_rb_pkg.sv
// shared constants, types and helpers for the uart ring buffer block
package uart_rb_pkg;

    localparam int FIFO_DEPTH  = 512;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = PTR_W + 1;
    localparam int STAT_W      = 10;
    localparam int BYTE_W      = 8;
    localparam int OP_W        = 3;
    localparam int TALLY_W     = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // operation codes on the request channel
    localparam logic [OP_W-1:0] OP_HOST_WRITE = 3'd0;
    localparam logic [OP_W-1:0] OP_HOST_READ  = 3'd1;
    localparam logic [OP_W-1:0] OP_TX_SLOT    = 3'd2;
    localparam logic [OP_W-1:0] OP_RX_BYTE    = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

    typedef enum logic [2:0] {
        KIND_WRITE,
        KIND_READ,
        KIND_TX_SLOT,
        KIND_RX_BYTE,
        KIND_CLEAR,
        KIND_NONE
    } kind_t;

    // classified request as held in the queue
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic              bad;
        logic              last;
    } item_t;

    // result fields known at issue, byte filled in from the ram later
    typedef struct packed {
        logic               popped;
        logic               src_rx;
        logic               accepted;
        logic [TALLY_W-1:0] burst_count;
        logic [STAT_W-1:0]  tx_free;
        logic [STAT_W-1:0]  rx_level;
        logic               tx_pending;
        logic               rx_dropped;
    } pend_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  byte_out;
        logic               byte_valid;
        logic               accepted;
        logic [TALLY_W-1:0] burst_count;
        logic [STAT_W-1:0]  tx_free;
        logic [STAT_W-1:0]  rx_level;
        logic               tx_pending;
        logic               rx_dropped;
    } result_t;

    function automatic logic [PTR_W-1:0] next_index(input logic [PTR_W-1:0] idx);
        if (idx == PTR_W'(FIFO_DEPTH - 1))
        begin
            return '0;
        end
        return idx + PTR_W'(1);
    endfunction

endpackage

// File: rtl/core/uart_rb_if.sv
// request and response channel interfaces of the uart ring buffer block
interface uart_rb_req_if import uart_rb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] byte_in;
    logic              noise_error;
    logic              framing_error;
    logic              last_in_burst;

    modport source (output valid, op, byte_in, noise_error, framing_error, last_in_burst,
                    input ready);
    modport sink   (input valid, op, byte_in, noise_error, framing_error, last_in_burst,
                    output ready);
endinterface

interface uart_rb_rsp_if import uart_rb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  byte_out;
    logic               byte_valid;
    logic               accepted;
    logic [TALLY_W-1:0] burst_count;
    logic [STAT_W-1:0]  tx_free;
    logic [STAT_W-1:0]  rx_level;
    logic               tx_pending;
    logic               rx_dropped;

    modport source (output valid, byte_out, byte_valid, accepted, burst_count, tx_free,
                    rx_level, tx_pending, rx_dropped,
                    input ready);
    modport sink   (input valid, byte_out, byte_valid, accepted, burst_count, tx_free,
                    rx_level, tx_pending, rx_dropped,
                    output ready);
endinterface

// File: rtl/core/uart_tx_rx_ring_buffers_unit.sv
// top level of the uart transmit and receive ring buffer block
//
// usage
//   req channel: one beat is one operation (host write, host read, transmit
//     slot free, received line byte, clear); accepted when valid and ready
//   rsp channel: exactly one beat per request, in request order, carrying the
//     popped byte (if any), store/drop flags, burst count and fifo status
// timing
//   a request beat enters a two entry queue; the back end issues it from the
//   queue (pointer and fill update, ram access) into the pending register,
//   and the response register loads from there; one request per cycle is
//   sustained while rsp.ready is high, limited by the single ram port each
//   fifo uses per operation
// reset
//   rst_n clears pointers, fill levels, burst tally and all valid flags;
//   the byte stores themselves are not cleared, no clearing pass is needed
// stall
//   while rsp.ready is low the response holds; the back end keeps one more
//   issued item, then the queue fills and req.ready drops
module uart_tx_rx_ring_buffers_unit import uart_rb_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    uart_rb_req_if.sink   req,
    uart_rb_rsp_if.source rsp
);

    // front end to queue
    logic  push_valid, push_ready;
    item_t push_item;

    // queue to back end
    logic  q_valid, q_pop;
    item_t q_item;

    uart_rb_front u_front (
        .req        (req),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    uart_rb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_item   (q_item),
        .pop        (q_pop)
    );

    uart_rb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

    // a beat never both pops a byte and stores one
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.byte_valid && rsp.accepted))
    else $error("response pops and stores in the same beat");

    // a dropped receive byte is never also reported as stored
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.rx_dropped && (rsp.accepted || rsp.byte_valid)))
    else $error("dropped byte reported as stored or popped");

    // transmit request tracks transmit free space
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.tx_pending == (rsp.tx_free != STAT_W'(FIFO_DEPTH))))
    else $error("tx_pending disagrees with tx_free");

    // a popped byte never comes with both fifos reported full
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.byte_valid) |-> (rsp.tx_free != '0
                                           || rsp.rx_level != STAT_W'(FIFO_DEPTH)))
    else $error("pop reported with both fifos full");

endmodule

// File: rtl/core/uart_rb_ram.sv
// generic single write port ram with registered read
module uart_rb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/uart_rb_front.sv
// request front end: decodes the operation and folds the error flags
module uart_rb_front import uart_rb_pkg::*; (
    uart_rb_req_if.sink req,
    output logic        push_valid,
    output item_t       push_item,
    input  logic        push_ready
);

    kind_t kind;

    always_comb
    begin
        unique case (req.op)
            OP_HOST_WRITE: kind = KIND_WRITE;
            OP_HOST_READ:  kind = KIND_READ;
            OP_TX_SLOT:    kind = KIND_TX_SLOT;
            OP_RX_BYTE:    kind = KIND_RX_BYTE;
            OP_CLEAR:      kind = KIND_CLEAR;
            default:       kind = KIND_NONE;
        endcase
    end

    assign push_valid     = req.valid;
    assign req.ready      = push_ready;
    assign push_item.kind = kind;
    assign push_item.data = req.byte_in;
    assign push_item.bad  = req.noise_error | req.framing_error;
    assign push_item.last = req.last_in_burst;

endmodule

// File: rtl/core/uart_rb_queue.sv
// short register queue between front end and back end
module uart_rb_queue import uart_rb_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    input  item_t push_item,
    output logic  push_ready,
    output logic  pop_valid,
    output item_t pop_item,
    input  logic  pop
);

    item_t               slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign push_ready = cnt_reg != (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop & pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/core/uart_rb_back.sv
// back end: fifo pointers, byte stores and the response register
module uart_rb_back import uart_rb_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  item_t         q_item,
    output logic          q_pop,
    uart_rb_rsp_if.source rsp
);

    localparam logic [CNT_W-1:0]   FULL      = CNT_W'(FIFO_DEPTH);
    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    logic [PTR_W-1:0]   tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [PTR_W-1:0]   rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [CNT_W-1:0]   tx_fill_reg, tx_fill_next, rx_fill_reg, rx_fill_next;
    logic [TALLY_W-1:0] tally_reg, tally_next, tally_cur;
    logic               pend_valid_reg, pend_valid_next;
    pend_t              pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic               tx_we, tx_re, rx_we, rx_re;
    logic [BYTE_W-1:0]  tx_rdata, rx_rdata;
    logic               out_free, issue, advance;
    logic               burst_op, bump;

    assign out_free = !out_valid_reg || rsp.ready;
    assign issue    = q_valid && (!pend_valid_reg || out_free);
    assign advance  = pend_valid_reg && out_free;
    assign q_pop    = issue;

    always_comb
    begin
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        tx_fill_next = tx_fill_reg;
        rx_fill_next = rx_fill_reg;
        tally_next   = tally_reg;
        tally_cur    = tally_reg;
        tx_we        = 1'b0;
        tx_re        = 1'b0;
        rx_we        = 1'b0;
        rx_re        = 1'b0;
        burst_op     = 1'b0;
        bump         = 1'b0;
        pend_next    = pend_reg;
        if (issue)
        begin
            pend_next.popped     = 1'b0;
            pend_next.src_rx     = 1'b0;
            pend_next.accepted   = 1'b0;
            pend_next.rx_dropped = 1'b0;
            unique case (q_item.kind)
                KIND_WRITE:
                begin
                    burst_op = 1'b1;
                    if (tx_fill_reg != FULL)
                    begin
                        tx_we              = 1'b1;
                        tx_head_next       = next_index(tx_head_reg);
                        tx_fill_next       = tx_fill_reg + 1'b1;
                        pend_next.accepted = 1'b1;
                        bump               = 1'b1;
                    end
                end
                KIND_READ:
                begin
                    burst_op = 1'b1;
                    if (rx_fill_reg != '0)
                    begin
                        rx_re            = 1'b1;
                        rx_tail_next     = next_index(rx_tail_reg);
                        rx_fill_next     = rx_fill_reg - 1'b1;
                        pend_next.popped = 1'b1;
                        pend_next.src_rx = 1'b1;
                        bump             = 1'b1;
                    end
                end
                KIND_TX_SLOT:
                begin
                    if (tx_fill_reg != '0)
                    begin
                        tx_re            = 1'b1;
                        tx_tail_next     = next_index(tx_tail_reg);
                        tx_fill_next     = tx_fill_reg - 1'b1;
                        pend_next.popped = 1'b1;
                    end
                end
                KIND_RX_BYTE:
                begin
                    if (q_item.bad || rx_fill_reg == FULL)
                    begin
                        pend_next.rx_dropped = 1'b1;
                    end
                    else
                    begin
                        rx_we              = 1'b1;
                        rx_head_next       = next_index(rx_head_reg);
                        rx_fill_next       = rx_fill_reg + 1'b1;
                        pend_next.accepted = 1'b1;
                    end
                end
                KIND_CLEAR:
                begin
                    tx_head_next = '0;
                    tx_tail_next = '0;
                    rx_head_next = '0;
                    rx_tail_next = '0;
                    tx_fill_next = '0;
                    rx_fill_next = '0;
                    tally_cur    = '0;
                end
                default:
                begin
                end
            endcase
            if (bump && tally_reg != TALLY_MAX)
            begin
                tally_cur = tally_reg + 1'b1;
            end
            tally_next             = (burst_op && q_item.last) ? '0 : tally_cur;
            pend_next.burst_count  = tally_cur;
            pend_next.tx_free      = STAT_W'(FULL - tx_fill_next);
            pend_next.rx_level     = STAT_W'(rx_fill_next);
            pend_next.tx_pending   = tx_fill_next != '0;
        end
    end

    always_comb
    begin
        pend_valid_next = issue ? 1'b1 : (advance ? 1'b0 : pend_valid_reg);
        out_valid_next  = advance ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
        out_next        = out_reg;
        if (advance)
        begin
            out_next.byte_out    = pend_reg.popped ? (pend_reg.src_rx ? rx_rdata : tx_rdata)
                                                   : '0;
            out_next.byte_valid  = pend_reg.popped;
            out_next.accepted    = pend_reg.accepted;
            out_next.burst_count = pend_reg.burst_count;
            out_next.tx_free     = pend_reg.tx_free;
            out_next.rx_level    = pend_reg.rx_level;
            out_next.tx_pending  = pend_reg.tx_pending;
            out_next.rx_dropped  = pend_reg.rx_dropped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_head_reg    <= '0;
            tx_tail_reg    <= '0;
            rx_head_reg    <= '0;
            rx_tail_reg    <= '0;
            tx_fill_reg    <= '0;
            rx_fill_reg    <= '0;
            tally_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            tx_head_reg    <= tx_head_next;
            tx_tail_reg    <= tx_tail_next;
            rx_head_reg    <= rx_head_next;
            rx_tail_reg    <= rx_tail_next;
            tx_fill_reg    <= tx_fill_next;
            rx_fill_reg    <= rx_fill_next;
            tally_reg      <= tally_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    uart_rb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_head_reg),
        .wdata (q_item.data),
        .re    (tx_re),
        .raddr (tx_tail_reg),
        .rdata (tx_rdata)
    );

    uart_rb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_head_reg),
        .wdata (q_item.data),
        .re    (rx_re),
        .raddr (rx_tail_reg),
        .rdata (rx_rdata)
    );

    assign rsp.valid       = out_valid_reg;
    assign rsp.byte_out    = out_reg.byte_out;
    assign rsp.byte_valid  = out_reg.byte_valid;
    assign rsp.accepted    = out_reg.accepted;
    assign rsp.burst_count = out_reg.burst_count;
    assign rsp.tx_free     = out_reg.tx_free;
    assign rsp.rx_level    = out_reg.rx_level;
    assign rsp.tx_pending  = out_reg.tx_pending;
    assign rsp.rx_dropped  = out_reg.rx_dropped;

endmodule

// File: tb/tb_uart_tx_rx_ring_buffers_unit.sv
// self-checking testbench for the uart transmit and receive ring buffer block
module tb_uart_tx_rx_ring_buffers_unit;
    import uart_rb_pkg::*;

    // op codes the block treats as status-only requests
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    localparam int MAX_GAP      = 19;
    localparam int SETTLE_TICKS = 20;
    localparam int RANDOM_ITEMS = 800;

    // one request beat as the testbench sees it
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data;
        logic              noise;
        logic              framing;
        logic              last;
    } line_op_t;

    // directed row: request, and a hand-written response where it is obvious
    typedef struct {
        line_op_t op_beat;
        bit       typed;
        result_t  want;
    } probe_row_t;

    logic clk;
    logic rst_n;

    uart_rb_req_if req_ch ();
    uart_rb_rsp_if rsp_ch ();

    uart_tx_rx_ring_buffers_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of both rings, their pointers, fill levels and the burst tally
    logic [BYTE_W-1:0]  tx_ring [FIFO_DEPTH];
    logic [BYTE_W-1:0]  rx_ring [FIFO_DEPTH];
    logic [PTR_W-1:0]   tx_wr = '0;
    logic [PTR_W-1:0]   tx_rd = '0;
    logic [PTR_W-1:0]   rx_wr = '0;
    logic [PTR_W-1:0]   rx_rd = '0;
    int unsigned        tx_count = 0;
    int unsigned        rx_count = 0;
    logic [TALLY_W-1:0] tally = '0;

    // responses still owed by the block, oldest first
    result_t     expected_status[$];
    int unsigned error_count = 0;
    // random idling on both channels; cleared for back-to-back stretches
    bit          gaps_on = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin : watchdog
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p);
        return PTR_W'((int'(p) + 1) % FIFO_DEPTH);
    endfunction

    // applies one request to the shadow state and returns the response it earns
    function automatic result_t predict_status(input line_op_t b);
        result_t r;
        logic    burst_op;
        r = '0;
        burst_op = 1'b0;
        case (b.op)
            OP_HOST_WRITE:
            begin
                burst_op = 1'b1;
                // full transmit ring drops the byte silently
                if (tx_count < FIFO_DEPTH)
                begin
                    tx_ring[tx_wr] = b.data;
                    tx_wr = ring_advance(tx_wr);
                    tx_count++;
                    r.accepted = 1'b1;
                    if (tally != '1)
                    begin
                        tally++;
                    end
                end
            end
            OP_HOST_READ:
            begin
                burst_op = 1'b1;
                if (rx_count != 0)
                begin
                    r.byte_out = rx_ring[rx_rd];
                    r.byte_valid = 1'b1;
                    rx_rd = ring_advance(rx_rd);
                    rx_count--;
                    if (tally != '1)
                    begin
                        tally++;
                    end
                end
            end
            OP_TX_SLOT:
            begin
                if (tx_count != 0)
                begin
                    r.byte_out = tx_ring[tx_rd];
                    r.byte_valid = 1'b1;
                    tx_rd = ring_advance(tx_rd);
                    tx_count--;
                end
            end
            OP_RX_BYTE:
            begin
                // line errors and overrun both discard the byte
                if (b.noise || b.framing || rx_count >= FIFO_DEPTH)
                begin
                    r.rx_dropped = 1'b1;
                end
                else
                begin
                    rx_ring[rx_wr] = b.data;
                    rx_wr = ring_advance(rx_wr);
                    rx_count++;
                    r.accepted = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                tx_wr = '0;
                tx_rd = '0;
                rx_wr = '0;
                rx_rd = '0;
                tx_count = 0;
                rx_count = 0;
                tally = '0;
            end
            default:
            begin
            end
        endcase
        // the count reported includes this item; the end of a burst rewinds it after
        r.burst_count = tally;
        if (burst_op && b.last)
        begin
            tally = '0;
        end
        r.tx_free = STAT_W'(FIFO_DEPTH - tx_count);
        r.rx_level = STAT_W'(rx_count);
        r.tx_pending = (tx_count != 0);
        return r;
    endfunction

    function automatic line_op_t beat(input logic [OP_W-1:0] op, input int unsigned data,
                                      input int unsigned noise, input int unsigned framing,
                                      input int unsigned last);
        line_op_t b;
        b.op = op;
        b.data = BYTE_W'(data);
        b.noise = (noise != 0);
        b.framing = (framing != 0);
        b.last = (last != 0);
        return b;
    endfunction

    function automatic result_t status(input int unsigned byte_out, input int unsigned popped,
                                       input int unsigned stored, input int unsigned burst,
                                       input int unsigned free, input int unsigned level,
                                       input int unsigned pending, input int unsigned dropped);
        result_t r;
        r.byte_out = BYTE_W'(byte_out);
        r.byte_valid = (popped != 0);
        r.accepted = (stored != 0);
        r.burst_count = TALLY_W'(burst);
        r.tx_free = STAT_W'(free);
        r.rx_level = STAT_W'(level);
        r.tx_pending = (pending != 0);
        r.rx_dropped = (dropped != 0);
        return r;
    endfunction

    // random byte, clean line flags
    function automatic line_op_t rand_beat(input logic [OP_W-1:0] op, input logic last);
        line_op_t b;
        b.op = op;
        b.data = BYTE_W'($urandom);
        b.noise = 1'b0;
        b.framing = 1'b0;
        b.last = last;
        return b;
    endfunction

    // drives one request beat after a random gap; the response owed is queued
    // at the edge that accepts the beat
    task automatic send_beat(input line_op_t b, input bit typed, input result_t want);
        int      gap;
        result_t guess;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        // valid stays high across back-to-back beats
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.op            <= b.op;
        req_ch.byte_in       <= b.data;
        req_ch.noise_error   <= b.noise;
        req_ch.framing_error <= b.framing;
        req_ch.last_in_burst <= b.last;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        guess = predict_status(b);
        expected_status.push_back(typed ? want : guess);
    endtask

    task automatic send_op(input line_op_t b);
        send_beat(b, 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [TALLY_W-1:0] want,
                               input logic [TALLY_W-1:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // response side: random stalls on ready, every accepted beat checked
    // against the oldest owed response
    initial
    begin : response_side
        int      stall;
        result_t got;
        result_t want;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
            got.byte_out    = rsp_ch.byte_out;
            got.byte_valid  = rsp_ch.byte_valid;
            got.accepted    = rsp_ch.accepted;
            got.burst_count = rsp_ch.burst_count;
            got.tx_free     = rsp_ch.tx_free;
            got.rx_level    = rsp_ch.rx_level;
            got.tx_pending  = rsp_ch.tx_pending;
            got.rx_dropped  = rsp_ch.rx_dropped;
            if (expected_status.size() == 0)
            begin
                error_count++;
                $display("%0t: response beat with nothing owed, expected none, actual %h",
                         $time, got);
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("byte_out", TALLY_W'(want.byte_out), TALLY_W'(got.byte_out));
                check_field("byte_valid", TALLY_W'(want.byte_valid), TALLY_W'(got.byte_valid));
                check_field("accepted", TALLY_W'(want.accepted), TALLY_W'(got.accepted));
                check_field("burst_count", want.burst_count, got.burst_count);
                check_field("tx_free", TALLY_W'(want.tx_free), TALLY_W'(got.tx_free));
                check_field("rx_level", TALLY_W'(want.rx_level), TALLY_W'(got.rx_level));
                check_field("tx_pending", TALLY_W'(want.tx_pending), TALLY_W'(got.tx_pending));
                check_field("rx_dropped", TALLY_W'(want.rx_dropped), TALLY_W'(got.rx_dropped));
            end
        end
    end

    // request side: directed table, fill and drain of both rings, then random traffic
    initial
    begin : request_side
        probe_row_t probe_table[$];
        line_op_t   b;
        int         done_items;
        int         run_len;
        int         pick;

        req_ch.valid         <= 1'b0;
        req_ch.op            <= OP_HOST_WRITE;
        req_ch.byte_in       <= '0;
        req_ch.noise_error   <= 1'b0;
        req_ch.framing_error <= 1'b0;
        req_ch.last_in_burst <= 1'b0;
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // pops on empty rings right after reset
        probe_table.push_back('{beat(OP_HOST_READ, 8'h00, 0, 0, 0), 1'b1,
                                status(8'h00, 0, 0, 0, 512, 0, 0, 0)});
        probe_table.push_back('{beat(OP_TX_SLOT, 8'h00, 0, 0, 0), 1'b1,
                                status(8'h00, 0, 0, 0, 512, 0, 0, 0)});
        // write burst interrupted by line traffic; last on a non-burst op is ignored
        probe_table.push_back('{beat(OP_HOST_WRITE, 8'hFF, 0, 0, 0), 1'b1,
                                status(8'h00, 0, 1, 1, 511, 0, 1, 0)});
        probe_table.push_back('{beat(OP_RX_BYTE, 8'h12, 0, 0, 1), 1'b1,
                                status(8'h00, 0, 1, 1, 511, 1, 1, 0)});
        probe_table.push_back('{beat(OP_TX_SLOT, 8'h00, 0, 0, 1), 1'b1,
                                status(8'hFF, 1, 0, 1, 512, 1, 0, 0)});
        probe_table.push_back('{beat(OP_HOST_WRITE, 8'h00, 0, 0, 1), 1'b1,
                                status(8'h00, 0, 1, 2, 511, 1, 1, 0)});
        // line errors discard the byte
        probe_table.push_back('{beat(OP_RX_BYTE, 8'hA5, 1, 0, 0), 1'b1,
                                status(8'h00, 0, 0, 0, 511, 1, 1, 1)});
        probe_table.push_back('{beat(OP_RX_BYTE, 8'h5A, 0, 1, 0), 1'b1,
                                status(8'h00, 0, 0, 0, 511, 1, 1, 1)});
        probe_table.push_back('{beat(OP_RX_BYTE, 8'hC3, 1, 1, 0), 1'b1,
                                status(8'h00, 0, 0, 0, 511, 1, 1, 1)});
        probe_table.push_back('{beat(OP_RX_BYTE, 8'hFF, 0, 0, 0), 1'b1,
                                status(8'h00, 0, 1, 0, 511, 2, 1, 0)});
        // read burst, then a read on the emptied ring
        probe_table.push_back('{beat(OP_HOST_READ, 8'h00, 0, 0, 0), 1'b1,
                                status(8'h12, 1, 0, 1, 511, 1, 1, 0)});
        probe_table.push_back('{beat(OP_HOST_READ, 8'h00, 0, 0, 1), 1'b1,
                                status(8'hFF, 1, 0, 2, 511, 0, 1, 0)});
        probe_table.push_back('{beat(OP_HOST_READ, 8'h00, 0, 0, 1), 1'b1,
                                status(8'h00, 0, 0, 0, 511, 0, 1, 0)});
        probe_table.push_back('{beat(OP_HOST_WRITE, 8'h80, 0, 0, 0), 1'b1,
                                status(8'h00, 0, 1, 1, 510, 0, 1, 0)});
        // spare op codes report status only, tally held
        probe_table.push_back('{beat(OP_SPARE_A, 8'hFF, 1, 1, 1), 1'b1,
                                status(8'h00, 0, 0, 1, 510, 0, 1, 0)});
        probe_table.push_back('{beat(OP_SPARE_B, 8'hFF, 1, 1, 1), 1'b1,
                                status(8'h00, 0, 0, 1, 510, 0, 1, 0)});
        probe_table.push_back('{beat(OP_SPARE_C, 8'hFF, 1, 1, 1), 1'b1,
                                status(8'h00, 0, 0, 1, 510, 0, 1, 0)});
        // clear empties both rings and the tally
        probe_table.push_back('{beat(OP_CLEAR, 8'hFF, 1, 1, 1), 1'b1,
                                status(8'h00, 0, 0, 0, 512, 0, 0, 0)});
        probe_table.push_back('{beat(OP_TX_SLOT, 8'h00, 0, 0, 0), 1'b1,
                                status(8'h00, 0, 0, 0, 512, 0, 0, 0)});
        probe_table.push_back('{beat(OP_HOST_READ, 8'h00, 0, 0, 0), 1'b1,
                                status(8'h00, 0, 0, 0, 512, 0, 0, 0)});
        // left to the predictor
        probe_table.push_back('{beat(OP_HOST_WRITE, 8'h01, 0, 0, 0), 1'b0, '0});
        probe_table.push_back('{beat(OP_RX_BYTE, 8'h7E, 0, 0, 0), 1'b0, '0});
        probe_table.push_back('{beat(OP_HOST_READ, 8'h00, 0, 0, 1), 1'b0, '0});
        probe_table.push_back('{beat(OP_TX_SLOT, 8'h00, 1, 0, 1), 1'b0, '0});

        foreach (probe_table[i])
        begin
            send_beat(probe_table[i].op_beat, probe_table[i].typed, probe_table[i].want);
        end

        // flood the transmit ring past full, then the receive ring into overrun
        gaps_on = ($urandom_range(0, 3) != 0);
        while (tx_count < FIFO_DEPTH)
        begin
            send_op(rand_beat(OP_HOST_WRITE, ($urandom_range(0, 31) == 0)));
        end
        repeat (3) send_op(rand_beat(OP_HOST_WRITE, 1'b0));
        gaps_on = ($urandom_range(0, 3) != 0);
        while (rx_count < FIFO_DEPTH)
        begin
            b = rand_beat(OP_RX_BYTE, 1'($urandom));
            b.noise = ($urandom_range(0, 15) == 0);
            b.framing = ($urandom_range(0, 15) == 0);
            send_op(b);
        end
        repeat (3) send_op(rand_beat(OP_RX_BYTE, 1'b0));

        // drain both in bursts of random length, one pop past empty each
        gaps_on = ($urandom_range(0, 3) != 0);
        while (rx_count != 0)
        begin
            send_op(rand_beat(OP_HOST_READ, ($urandom_range(0, 7) == 0)));
        end
        send_op(rand_beat(OP_HOST_READ, 1'b1));
        while (tx_count != 0)
        begin
            send_op(rand_beat(OP_TX_SLOT, 1'($urandom)));
        end
        send_op(rand_beat(OP_TX_SLOT, 1'b0));

        // random episodes: well-formed bursts and streams, with some noise mixed in
        done_items = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            gaps_on = ($urandom_range(0, 4) != 0);
            pick = $urandom_range(0, 9);
            run_len = $urandom_range(1, 24);
            for (int i = 0; i < run_len; i++)
            begin
                case (pick)
                    0, 1:
                    begin
                        b = rand_beat(OP_HOST_WRITE, (i == run_len - 1));
                    end
                    2, 3:
                    begin
                        b = rand_beat(OP_HOST_READ, (i == run_len - 1));
                    end
                    4, 5:
                    begin
                        b = rand_beat(OP_RX_BYTE, 1'($urandom));
                        b.noise = ($urandom_range(0, 7) == 0);
                        b.framing = ($urandom_range(0, 7) == 0);
                    end
                    6, 7:
                    begin
                        b = rand_beat(OP_TX_SLOT, 1'($urandom));
                    end
                    8:
                    begin
                        // any op, any fields; clear kept rare
                        b = $bits(line_op_t)'($urandom);
                        if (b.op == OP_CLEAR && $urandom_range(0, 3) != 0)
                        begin
                            b.op = OP_HOST_WRITE;
                        end
                    end
                    default:
                    begin
                        // data-moving ops with random flags and burst ends
                        b = $bits(line_op_t)'($urandom);
                        b.op = OP_W'($urandom_range(OP_HOST_WRITE, OP_RX_BYTE));
                    end
                endcase
                send_op(b);
            end
            done_items += run_len;
        end

        req_ch.valid <= 1'b0;
        gaps_on = 1'b1;
        while (expected_status.size() != 0)
        begin
            @(posedge clk);
        end
        // then let the clock run on to catch any stray response beat
        repeat (SETTLE_TICKS) @(posedge clk);
        if (error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
